>>> design/assert_macros.svh
// Assertion helpers included by the fit block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> design/orf_pkg.sv
// ----------------------------------------------------------------------------
// orf_pkg
// Types, sizes and codes shared by the orthogonal regression fit block.
// ----------------------------------------------------------------------------
package orf_pkg;

  localparam int MaxSamples = 1024;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CntW       = $clog2(MaxSamples + 1);
  localparam int SumW       = 32 + CntW;
  localparam int MomW       = 64 + CntW;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatCovZero = 2'd1;
  localparam logic [1:0] StatDropped = 2'd2;

  typedef struct packed {
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic               last_sample;
  } orf_in_t;

  typedef struct packed {
    logic signed [31:0] intercept;
    logic signed [31:0] slope;
    logic [1:0]         fit_status;
  } orf_out_t;

  typedef enum logic {
    OpDiv,
    OpSqrt
  } unit_op_e;

  typedef struct packed {
    logic     go;
    unit_op_e op;
  } unit_req_t;

  typedef enum logic [4:0] {
    StIdle,
    StP1,
    StXDiv,
    StYDiv,
    StP2,
    StVxDiv,
    StVyDiv,
    StCDiv,
    StCheck,
    StMdm,
    StMcm,
    StRad,
    StSqrt,
    StNum,
    StQDiv,
    StSlope,
    StIMul,
    StIcpt
  } orf_state_e;

endpackage

>>> design/orf_divsqrt.sv
// ----------------------------------------------------------------------------
// orf_divsqrt
// Shared restoring unit: 128/64 unsigned divide (one quotient bit a cycle)
// or 128-bit integer square root (one root bit a cycle).
// ----------------------------------------------------------------------------
module orf_divsqrt
  import orf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  unit_req_t    req_i,
  input  logic [127:0] num_i,
  input  logic [63:0]  den_i,
  output logic         done_o,
  output logic [127:0] quo_o
);

  logic         busy_q;
  logic [6:0]   cnt_q;
  unit_op_e     op_q;
  logic [66:0]  rem_q, rem_d;
  logic [127:0] sh_q, sh_d;
  logic [127:0] q_q, q_d;
  logic [63:0]  den_q;
  logic [66:0]  r2, sub;
  logic [67:0]  diff;
  logic         ge;

  always_comb begin
    if (op_q == OpDiv) begin
      r2   = {rem_q[65:0], sh_q[127]};
      sub  = {3'b000, den_q};
      sh_d = {sh_q[126:0], 1'b0};
    end else begin
      r2   = {rem_q[64:0], sh_q[127:126]};
      sub  = {1'b0, q_q[63:0], 2'b01};
      sh_d = {sh_q[125:0], 2'b00};
    end
    diff  = {1'b0, r2} - {1'b0, sub};
    ge    = !diff[67];
    rem_d = ge ? diff[66:0] : r2;
    q_d   = {q_q[126:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= (req_i.op == OpDiv) ? 7'd127 : 7'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      op_q  <= req_i.op;
      rem_q <= '0;
      sh_q  <= num_i;
      q_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
      q_q   <= q_d;
    end
  end

  assign quo_o = q_q;

endmodule

>>> design/orthogonal_regression_fit.sv
// ----------------------------------------------------------------------------
// orthogonal_regression_fit
// Collects Q16.16 (x, y) pairs and fits an orthogonal (Deming) line on the
// pair marked last.
// ----------------------------------------------------------------------------
//  port        dir  handshake               payload
//  in_i        in   start_i & !busy_o       x_value, y_value, last_sample
//  res_o       out  res_valid_o, one cycle  intercept, slope, fit_status
//
//  A pair that is not last is accepted and busy_o stays low.
//  A last pair holds busy_o high through the mean pass, two mean divides,
//  the moment pass, three moment divides, the square root and the slope
//  divide; it ends after the covariance divide when the covariance is zero.
//  Reset clears the pair count and the dropped flag; the stores need none.
//  The result strobe lasts one cycle and cannot be held off.
module orthogonal_regression_fit
  import orf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  orf_in_t  in_i,
  output logic     busy_o,
  output logic     res_valid_o,
  output orf_out_t res_o
);

  orf_state_e state_q, state_d;

  logic [CntW-1:0] cnt_q, idx_q;
  logic            ovf_q;
  logic [2:0]      ph_q;
  logic            rd_vld_q;
  logic            launched_q;

  logic [31:0] x_mem [MaxSamples];
  logic [31:0] y_mem [MaxSamples];
  logic [31:0] x_rd_q, y_rd_q;

  logic signed [SumW-1:0] sx_q, sy_q;
  logic signed [31:0]     xbar_q, ybar_q, slope_q;
  logic [31:0]            dxm_q, dym_q;
  logic                   dxs_q, dys_q;
  logic [MomW-1:0]        sxx_q, syy_q;
  logic signed [MomW:0]   sxy_q;
  logic [63:0]            vxx_q, vyy_q, cm_q, dm_q, num_q;
  logic                   cneg_q, dneg_q;
  logic [127:0]           acc_q, acc_d, rad_q;
  logic [63:0]            mul_q;
  logic [31:0]            mul_a, mul_b;

  logic         accept, full, wr_en;
  unit_req_t    ureq;
  logic [127:0] unum;
  logic [63:0]  uden;
  logic         udone;
  logic [127:0] uquo;

  logic [SumW-1:0] sxm, sym;
  logic [MomW:0]   sxym;
  logic [32:0]     dx, dy;
  logic [63:0]     op64, qm;
  logic [128:0]    rsum;
  logic [64:0]     nsum;
  logic [47:0]     tmag;
  logic [49:0]     ic, tsg;
  logic            isign;
  orf_out_t        res_d;
  logic            fin;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;
  assign full   = (cnt_q == CntW'(MaxSamples));
  assign wr_en  = accept && !full;

  // sample stores
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      x_mem[cnt_q[AddrW-1:0]] <= in_i.x_value;
      y_mem[cnt_q[AddrW-1:0]] <= in_i.y_value;
    end
  end

  always_ff @(posedge clk_i) begin
    x_rd_q <= x_mem[idx_q[AddrW-1:0]];
    y_rd_q <= y_mem[idx_q[AddrW-1:0]];
  end

  orf_divsqrt u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .num_i  (unum),
    .den_i  (uden),
    .done_o (udone),
    .quo_o  (uquo)
  );

  // magnitudes and deviations
  always_comb begin
    sxm  = sx_q[SumW-1] ? SumW'(-sx_q) : SumW'(sx_q);
    sym  = sy_q[SumW-1] ? SumW'(-sy_q) : SumW'(sy_q);
    sxym = sxy_q[MomW] ? (MomW+1)'(-sxy_q) : (MomW+1)'(sxy_q);
    dx   = {x_rd_q[31], x_rd_q} - {xbar_q[31], xbar_q};
    dy   = {y_rd_q[31], y_rd_q} - {ybar_q[31], ybar_q};
    op64 = (state_q == StMdm) ? dm_q : cm_q;
  end

  // shared unit requests
  always_comb begin
    ureq.go = 1'b0;
    ureq.op = OpDiv;
    unum    = '0;
    uden    = 64'(cnt_q);
    case (state_q)
      StXDiv:  unum = 128'(sxm);
      StYDiv:  unum = 128'(sym);
      StVxDiv: unum = 128'(sxx_q);
      StVyDiv: unum = 128'(syy_q);
      StCDiv:  unum = 128'(sxym);
      StSqrt: begin
        unum    = rad_q;
        ureq.op = OpSqrt;
      end
      StQDiv: begin
        unum = {49'd0, num_q, 15'd0};
        uden = cm_q;
      end
      default: unum = '0;
    endcase
    if (state_q inside {StXDiv, StYDiv, StVxDiv, StVyDiv, StCDiv, StSqrt, StQDiv}) begin
      ureq.go = !launched_q;
    end
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StP2: begin
        case (ph_q)
          3'd2: begin mul_a = dxm_q; mul_b = dxm_q; end
          3'd3: begin mul_a = dym_q; mul_b = dym_q; end
          3'd4: begin mul_a = dxm_q; mul_b = dym_q; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      StMdm, StMcm: begin
        case (ph_q)
          3'd0: begin mul_a = op64[31:0];  mul_b = op64[31:0];  end
          3'd1: begin mul_a = op64[31:0];  mul_b = op64[63:32]; end
          3'd2: begin mul_a = op64[63:32]; mul_b = op64[63:32]; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      StIMul: begin
        mul_a = slope_q[31] ? -slope_q : slope_q;
        mul_b = xbar_q[31] ? -xbar_q : xbar_q;
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= 64'(mul_a) * 64'(mul_b);
  end

  // square accumulation and late arithmetic
  always_comb begin
    case (ph_q)
      3'd1:    acc_d = 128'(mul_q);
      3'd2:    acc_d = acc_q + (128'(mul_q) << 33);
      3'd3:    acc_d = acc_q + (128'(mul_q) << 64);
      default: acc_d = '0;
    endcase
    rsum = 129'(rad_q) + 129'({acc_q[125:0], 2'b00});
    nsum = 65'(uquo[63:0]) + 65'(dm_q);
    qm   = (uquo[127:64] != '0) ? '1 : uquo[63:0];
    tmag  = mul_q[63:16];
    isign = slope_q[31] ^ xbar_q[31];
    tsg   = isign ? -{2'b00, tmag} : {2'b00, tmag};
    ic    = {{18{ybar_q[31]}}, ybar_q} - tsg;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    fin     = 1'b0;
    res_d   = '0;
    res_d.fit_status = StatCovZero;
    case (state_q)
      StIdle:  if (accept && in_i.last_sample) state_d = StP1;
      StP1:    if (idx_q == cnt_q && !rd_vld_q) state_d = StXDiv;
      StXDiv:  if (udone) state_d = StYDiv;
      StYDiv:  if (udone) state_d = StP2;
      StP2:    if (ph_q == 3'd5 && (idx_q + 1'b1) == cnt_q) state_d = StVxDiv;
      StVxDiv: if (udone) state_d = StVyDiv;
      StVyDiv: if (udone) state_d = StCDiv;
      StCDiv:  if (udone) state_d = StCheck;
      StCheck: begin
        if (cm_q == '0) begin
          fin     = 1'b1;
          state_d = StIdle;
        end else begin
          state_d = StMdm;
        end
      end
      StMdm:   if (ph_q == 3'd3) state_d = StMcm;
      StMcm:   if (ph_q == 3'd3) state_d = StRad;
      StRad:   state_d = StSqrt;
      StSqrt:  if (udone) state_d = StNum;
      StNum:   state_d = StQDiv;
      StQDiv:  if (udone) state_d = StSlope;
      StSlope: state_d = StIMul;
      StIMul:  state_d = StIcpt;
      StIcpt: begin
        fin     = 1'b1;
        state_d = StIdle;
        res_d.slope      = slope_q;
        res_d.fit_status = ovf_q ? StatDropped : StatOk;
        if (ic[49:31] == '0 || ic[49:31] == '1) begin
          res_d.intercept = ic[31:0];
        end else begin
          res_d.intercept = ic[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      ph_q        <= '0;
      rd_vld_q    <= 1'b0;
      launched_q  <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_o <= fin;
      if (wr_en) cnt_q <= cnt_q + 1'b1;
      if (accept && full) ovf_q <= 1'b1;
      if (fin) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
      if (ureq.go) launched_q <= 1'b1;
      else if (udone) launched_q <= 1'b0;
      rd_vld_q <= 1'b0;
      case (state_q)
        StIdle: begin
          idx_q <= '0;
          ph_q  <= '0;
        end
        StP1: begin
          if (idx_q != cnt_q) begin
            idx_q    <= idx_q + 1'b1;
            rd_vld_q <= 1'b1;
          end else if (!rd_vld_q) begin
            idx_q <= '0;
          end
        end
        StP2: begin
          if (ph_q == 3'd5) begin
            ph_q  <= '0;
            idx_q <= idx_q + 1'b1;
          end else begin
            ph_q <= ph_q + 3'd1;
          end
        end
        StMdm, StMcm: ph_q <= (ph_q == 3'd3) ? 3'd0 : ph_q + 3'd1;
        default: ph_q <= '0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (fin) res_o <= res_d;
    case (state_q)
      StIdle: begin
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        syy_q <= '0;
        sxy_q <= '0;
      end
      StP1: begin
        if (rd_vld_q) begin
          sx_q <= sx_q + SumW'($signed(x_rd_q));
          sy_q <= sy_q + SumW'($signed(y_rd_q));
        end
      end
      StXDiv: if (udone) xbar_q <= sx_q[SumW-1] ? -uquo[31:0] : uquo[31:0];
      StYDiv: if (udone) ybar_q <= sy_q[SumW-1] ? -uquo[31:0] : uquo[31:0];
      StP2: begin
        case (ph_q)
          3'd1: begin
            dxs_q <= dx[32];
            dys_q <= dy[32];
            dxm_q <= dx[32] ? 32'(-dx) : dx[31:0];
            dym_q <= dy[32] ? 32'(-dy) : dy[31:0];
          end
          3'd3: sxx_q <= sxx_q + MomW'(mul_q);
          3'd4: syy_q <= syy_q + MomW'(mul_q);
          3'd5: begin
            // opposite deviation signs subtract from the covariance
            if (dxs_q ^ dys_q) sxy_q <= sxy_q - (MomW+1)'(mul_q);
            else               sxy_q <= sxy_q + (MomW+1)'(mul_q);
          end
          default: dxs_q <= dxs_q;
        endcase
      end
      StVxDiv: if (udone) vxx_q <= uquo[63:0];
      StVyDiv: if (udone) vyy_q <= uquo[63:0];
      StCDiv: begin
        if (udone) begin
          cm_q   <= uquo[63:0];
          cneg_q <= sxy_q[MomW];
        end
      end
      StCheck: begin
        dneg_q <= vyy_q < vxx_q;
        dm_q   <= (vyy_q < vxx_q) ? vxx_q - vyy_q : vyy_q - vxx_q;
      end
      StMdm: begin
        acc_q <= acc_d;
        if (ph_q == 3'd3) rad_q <= acc_d;
      end
      StMcm: acc_q <= acc_d;
      StRad: begin
        // saturate the radicand at all ones
        if (acc_q[127:126] != 2'b00 || rsum[128]) rad_q <= '1;
        else rad_q <= rsum[127:0];
      end
      StNum: begin
        if (dneg_q) num_q <= (uquo[63:0] > dm_q) ? uquo[63:0] - dm_q : '0;
        else        num_q <= nsum[64] ? '1 : nsum[63:0];
      end
      StSlope: begin
        if (cneg_q) slope_q <= (qm >= 64'h8000_0000) ? 32'sh8000_0000 : -qm[31:0];
        else        slope_q <= (qm >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : qm[31:0];
      end
      default: acc_q <= acc_q;
    endcase
  end

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_res_when_idle, res_valid_o, !busy_o)
  `ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CntW'(MaxSamples))
  `ASSERT_IMPL(a_cov_zero_out, res_valid_o && res_o.fit_status == StatCovZero, res_o.slope == '0 && res_o.intercept == '0)
  `ASSERT_NEXT(a_last_goes_busy, accept && in_i.last_sample, busy_o)

endmodule

>>> tb/sv/orthogonal_regression_fit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// orthogonal_regression_fit_test
// Loads sets of Q16.16 pairs into the fit block, with random pauses between
// bursts. A line fit is computed here on every set, and each result strobe is
// checked field by field against the oldest fit still waiting.
// ----------------------------------------------------------------------------
module orthogonal_regression_fit_test
  import orf_pkg::*;
();

  localparam int IdleLimit = 60000;
  localparam int DrainCycles = 12000;

  typedef struct {
    orf_in_t  pair;
    bit       typed;
    orf_out_t fit;
  } row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start_i = 1'b0;
  orf_in_t  in_i = '0;
  logic     busy_o;
  logic     res_valid_o;
  orf_out_t res_o;

  orthogonal_regression_fit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [31:0] set_x [MaxSamples];
  logic signed [31:0] set_y [MaxSamples];
  int       set_count = 0;
  bit       set_dropped = 1'b0;
  orf_out_t pending_fits [$];
  orf_out_t typed_fits [$];
  bit       typed_flags [$];
  row_t     rows [$];
  int       failures = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;
  bit       pause_once = 1'b0;

  function automatic logic [63:0] clamp64(logic [127:0] v);
    return (|v[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
  endfunction

  function automatic logic [63:0] floor_root(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] cand;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= v) r = cand;
    end
    return r;
  endfunction

  // Deming fit over the current set, error-variance ratio one.
  function automatic orf_out_t fit_line();
    orf_out_t    f;
    longint      sx, sy, xbar, ybar, dx, dy, slope, prod, icpt;
    logic [63:0] mx, my, vxx, vyy, cm, dm, root, num, qm;
    logic [127:0] sxx, syy, pos, neg, s4, rad;
    logic [129:0] wide;
    bit          cneg, dneg;
    f = '0;
    f.fit_status = StatCovZero;
    sx = 0; sy = 0; sxx = '0; syy = '0; pos = '0; neg = '0;
    for (int i = 0; i < set_count; i++) begin
      sx += longint'(set_x[i]);
      sy += longint'(set_y[i]);
    end
    xbar = sx / longint'(set_count);
    ybar = sy / longint'(set_count);
    for (int i = 0; i < set_count; i++) begin
      dx = longint'(set_x[i]) - xbar;
      dy = longint'(set_y[i]) - ybar;
      mx = dx < 0 ? 64'(-dx) : 64'(dx);
      my = dy < 0 ? 64'(-dy) : 64'(dy);
      sxx += {64'd0, mx} * {64'd0, mx};
      syy += {64'd0, my} * {64'd0, my};
      if ((dx < 0) != (dy < 0)) neg += {64'd0, mx} * {64'd0, my};
      else pos += {64'd0, mx} * {64'd0, my};
    end
    vxx = clamp64(sxx / 128'(set_count));
    vyy = clamp64(syy / 128'(set_count));
    cneg = pos < neg;
    cm = clamp64((cneg ? neg - pos : pos - neg) / 128'(set_count));
    if (cm == 0) return f;
    dneg = vyy < vxx;
    dm = dneg ? vxx - vyy : vyy - vxx;
    s4 = {64'd0, cm} * {64'd0, cm};
    if (|s4[127:126]) begin
      rad = '1;
    end else begin
      wide = {2'b0, {64'd0, dm} * {64'd0, dm}} + {s4, 2'b00};
      rad = (|wide[129:128]) ? '1 : wide[127:0];
    end
    root = floor_root(rad);
    if (dneg) num = root > dm ? root - dm : '0;
    else num = (root > ~dm) ? '1 : root + dm;
    qm = clamp64(({64'd0, num} << 15) / {64'd0, cm});
    if (cneg) slope = qm >= 64'h8000_0000 ? -64'sd2147483648 : -longint'(qm);
    else slope = qm >= 64'h7FFF_FFFF ? 64'sd2147483647 : longint'(qm);
    prod = slope * xbar;
    icpt = ybar - prod / 65536;
    if (icpt > 64'sd2147483647) icpt = 64'sd2147483647;
    if (icpt < -64'sd2147483648) icpt = -64'sd2147483648;
    f.slope = 32'(slope);
    f.intercept = 32'(icpt);
    f.fit_status = set_dropped ? StatDropped : StatOk;
    return f;
  endfunction

  task automatic check_fit(orf_out_t want, orf_out_t got, string tag);
    if (want.intercept !== got.intercept || want.slope !== got.slope ||
        want.fit_status !== got.fit_status) begin
      failures++;
      $display("%0t: %s mismatch: expected icpt=%h slope=%h st=%0d,",
               $time, tag, want.intercept, want.slope, want.fit_status,
               " got icpt=%h slope=%h st=%0d",
               got.intercept, got.slope, got.fit_status);
    end
  endtask

  // Accepted items feed the predictor; result strobes pop the oldest fit.
  always @(posedge clk_i) begin
    orf_out_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (res_valid_o) begin
        idle_cycles = 0;
        if (pending_fits.size() == 0) begin
          failures++;
          $display("%0t: unexpected result icpt=%h slope=%h st=%0d",
                   $time, res_o.intercept, res_o.slope, res_o.fit_status);
        end else begin
          check_fit(pending_fits.pop_front(), res_o, "predicted");
          if (typed_flags.pop_front()) check_fit(typed_fits.pop_front(), res_o, "table");
        end
      end
      if (start_i && !busy_o) begin
        idle_cycles = 0;
        if (set_count < MaxSamples) begin
          set_x[set_count] = in_i.x_value;
          set_y[set_count] = in_i.y_value;
          set_count++;
        end else begin
          set_dropped = 1'b1;
        end
        if (in_i.last_sample) begin
          want = fit_line();
          pending_fits.insert(pending_fits.size(), want);
          set_count = 0;
          set_dropped = 1'b0;
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL orthogonal_regression_fit");
        $finish;
      end
    end
  end

  // Present one item from the falling edge until it is taken.
  task automatic send_pair(orf_in_t p);
    bit taken;
    if (burst_left == 0) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    start_i = 1'b1;
    in_i = p;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
      @(negedge clk_i);
    end
  endtask

  function automatic orf_in_t mk(logic signed [31:0] x, logic signed [31:0] y, bit last);
    orf_in_t p;
    p.x_value = x;
    p.y_value = y;
    p.last_sample = last;
    return p;
  endfunction

  function automatic void add_row(orf_in_t p, bit typed, orf_out_t f);
    row_t r;
    r.pair = p;
    r.typed = typed;
    r.fit = f;
    rows.insert(rows.size(), r);
  endfunction

  // One set of n pairs: full-range noise, a noisy line, narrower noise, or a flat x.
  task automatic send_set(int n);
    int     style;
    longint gain, x, y;
    style = $urandom_range(0, 3);
    gain = longint'($signed($urandom_range(0, 1 << 19))) - (1 << 18);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: begin
          x = longint'($signed($urandom()));
          y = longint'($signed($urandom()));
        end
        1: begin
          x = longint'($signed($urandom_range(0, 1 << 22))) - (1 << 21);
          y = (x * gain) / 65536 + longint'($urandom_range(0, 2047)) - 1024;
        end
        2: begin
          x = longint'($signed($urandom_range(0, 1 << 26))) - (1 << 25);
          y = longint'($signed($urandom_range(0, 1 << 26))) - (1 << 25);
        end
        default: begin
          x = 12345;
          y = longint'($signed($urandom()));
        end
      endcase
      send_pair(mk(32'(x), 32'(y), i == n - 1));
      if (!pause_once && i == n - 1 && n > 3) begin
        // hold off until every fit has come back
        pause_once = 1'b1;
        start_i = 1'b0;
        wait (pending_fits.size() == 0);
        @(negedge clk_i);
      end
    end
  endtask

  initial begin
    row_t     r;
    orf_out_t zero_fit;
    orf_out_t unit_fit;
    int       sent;
    int       n;
    bit       overfilled;
    zero_fit = '0;
    zero_fit.fit_status = StatCovZero;
    unit_fit = '0;
    unit_fit.slope = 32'sh0001_0000;
    unit_fit.fit_status = StatOk;
    // single sample at the extremes
    add_row(mk(32'h7FFF_FFFF, 32'h8000_0000, 1), 1, zero_fit);
    add_row(mk(32'h8000_0000, 32'h7FFF_FFFF, 1), 1, zero_fit);
    // constant x gives zero covariance
    add_row(mk(0, 0, 0), 0, zero_fit);
    add_row(mk(0, 32'sd5 << 16, 1), 1, zero_fit);
    // identity line
    add_row(mk(0, 0, 0), 0, zero_fit);
    add_row(mk(32'sh0001_0000, 32'sh0001_0000, 1), 1, unit_fit);
    // extremes against each other
    add_row(mk(32'h8000_0000, 32'h8000_0000, 0), 0, zero_fit);
    add_row(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1), 0, zero_fit);
    add_row(mk(32'h8000_0000, 32'h7FFF_FFFF, 0), 0, zero_fit);
    add_row(mk(32'h7FFF_FFFF, 32'h8000_0000, 1), 0, zero_fit);
    add_row(mk(32'hFFFF_FFFF, 0, 0), 0, zero_fit);
    add_row(mk(32'h0000_0001, 32'hFFFF_FFFF, 0), 0, zero_fit);
    add_row(mk(32'h5555_5555, 32'hAAAA_AAAA, 1), 0, zero_fit);
    // steep line, slope saturates
    add_row(mk(0, 32'h8000_0000, 0), 0, zero_fit);
    add_row(mk(1, 32'h7FFF_FFFF, 1), 0, zero_fit);
    // flat line, negative covariance
    add_row(mk(32'sh0010_0000, 3, 0), 0, zero_fit);
    add_row(mk(-32'sh0010_0000, 5, 0), 0, zero_fit);
    add_row(mk(32'sh0020_0000, 1, 1), 0, zero_fit);

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.pair.last_sample) begin
        typed_flags.insert(typed_flags.size(), r.typed);
        if (r.typed) typed_fits.insert(typed_fits.size(), r.fit);
      end
      send_pair(r.pair);
    end

    sent = 0;
    overfilled = 1'b0;
    while (sent < 1630) begin
      if (!overfilled && sent > 300) begin
        // overfill the store, then close the set
        overfilled = 1'b1;
        n = MaxSamples + $urandom_range(2, 6);
        typed_flags.insert(typed_flags.size(), 1'b0);
        for (int i = 0; i < n; i++) begin
          send_pair(mk($urandom(), $urandom(), i == n - 1));
        end
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        typed_flags.insert(typed_flags.size(), 1'b0);
        send_set(n);
      end
      sent += n;
    end

    start_i = 1'b0;
    wait (pending_fits.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
    if (failures == 0 && pending_fits.size() == 0) begin
      $display("PASS orthogonal_regression_fit");
    end else begin
      $display("FAIL orthogonal_regression_fit");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/orf_pkg.sv
design/orf_divsqrt.sv
design/orthogonal_regression_fit.sv
tb/sv/orthogonal_regression_fit_test.sv
